### hw/rtl/aes128r_pkg.sv
// Package for the AES-128 round block: byte/word types, S-box, Rcon, GF helpers.
// No dependencies.
package aes128r_pkg;

  localparam int unsigned NUM_COLS = 4;
  localparam logic [3:0] ROUND_FIRST = 4'd1;
  localparam logic [3:0] ROUND_LAST  = 4'd10;
  localparam logic [7:0] GF_POLY     = 8'h1b;

  typedef logic [7:0]  byte_t;
  typedef logic [31:0] word_t;

  // Control decoded from the round index, shared by the lanes.
  typedef struct packed {
    logic       full;    // rounds 1..10: SubBytes/ShiftRows and key expansion
    logic       mix;     // rounds 1..9: MixColumns
    logic [7:0] rcon;
  } rnd_ctl_t;

  function automatic byte_t sbox(input byte_t a);
    byte_t r;
    case (a)
      8'h00: r=8'h63; 8'h01: r=8'h7c; 8'h02: r=8'h77; 8'h03: r=8'h7b;
      8'h04: r=8'hf2; 8'h05: r=8'h6b; 8'h06: r=8'h6f; 8'h07: r=8'hc5;
      8'h08: r=8'h30; 8'h09: r=8'h01; 8'h0a: r=8'h67; 8'h0b: r=8'h2b;
      8'h0c: r=8'hfe; 8'h0d: r=8'hd7; 8'h0e: r=8'hab; 8'h0f: r=8'h76;
      8'h10: r=8'hca; 8'h11: r=8'h82; 8'h12: r=8'hc9; 8'h13: r=8'h7d;
      8'h14: r=8'hfa; 8'h15: r=8'h59; 8'h16: r=8'h47; 8'h17: r=8'hf0;
      8'h18: r=8'had; 8'h19: r=8'hd4; 8'h1a: r=8'ha2; 8'h1b: r=8'haf;
      8'h1c: r=8'h9c; 8'h1d: r=8'ha4; 8'h1e: r=8'h72; 8'h1f: r=8'hc0;
      8'h20: r=8'hb7; 8'h21: r=8'hfd; 8'h22: r=8'h93; 8'h23: r=8'h26;
      8'h24: r=8'h36; 8'h25: r=8'h3f; 8'h26: r=8'hf7; 8'h27: r=8'hcc;
      8'h28: r=8'h34; 8'h29: r=8'ha5; 8'h2a: r=8'he5; 8'h2b: r=8'hf1;
      8'h2c: r=8'h71; 8'h2d: r=8'hd8; 8'h2e: r=8'h31; 8'h2f: r=8'h15;
      8'h30: r=8'h04; 8'h31: r=8'hc7; 8'h32: r=8'h23; 8'h33: r=8'hc3;
      8'h34: r=8'h18; 8'h35: r=8'h96; 8'h36: r=8'h05; 8'h37: r=8'h9a;
      8'h38: r=8'h07; 8'h39: r=8'h12; 8'h3a: r=8'h80; 8'h3b: r=8'he2;
      8'h3c: r=8'heb; 8'h3d: r=8'h27; 8'h3e: r=8'hb2; 8'h3f: r=8'h75;
      8'h40: r=8'h09; 8'h41: r=8'h83; 8'h42: r=8'h2c; 8'h43: r=8'h1a;
      8'h44: r=8'h1b; 8'h45: r=8'h6e; 8'h46: r=8'h5a; 8'h47: r=8'ha0;
      8'h48: r=8'h52; 8'h49: r=8'h3b; 8'h4a: r=8'hd6; 8'h4b: r=8'hb3;
      8'h4c: r=8'h29; 8'h4d: r=8'he3; 8'h4e: r=8'h2f; 8'h4f: r=8'h84;
      8'h50: r=8'h53; 8'h51: r=8'hd1; 8'h52: r=8'h00; 8'h53: r=8'hed;
      8'h54: r=8'h20; 8'h55: r=8'hfc; 8'h56: r=8'hb1; 8'h57: r=8'h5b;
      8'h58: r=8'h6a; 8'h59: r=8'hcb; 8'h5a: r=8'hbe; 8'h5b: r=8'h39;
      8'h5c: r=8'h4a; 8'h5d: r=8'h4c; 8'h5e: r=8'h58; 8'h5f: r=8'hcf;
      8'h60: r=8'hd0; 8'h61: r=8'hef; 8'h62: r=8'haa; 8'h63: r=8'hfb;
      8'h64: r=8'h43; 8'h65: r=8'h4d; 8'h66: r=8'h33; 8'h67: r=8'h85;
      8'h68: r=8'h45; 8'h69: r=8'hf9; 8'h6a: r=8'h02; 8'h6b: r=8'h7f;
      8'h6c: r=8'h50; 8'h6d: r=8'h3c; 8'h6e: r=8'h9f; 8'h6f: r=8'ha8;
      8'h70: r=8'h51; 8'h71: r=8'ha3; 8'h72: r=8'h40; 8'h73: r=8'h8f;
      8'h74: r=8'h92; 8'h75: r=8'h9d; 8'h76: r=8'h38; 8'h77: r=8'hf5;
      8'h78: r=8'hbc; 8'h79: r=8'hb6; 8'h7a: r=8'hda; 8'h7b: r=8'h21;
      8'h7c: r=8'h10; 8'h7d: r=8'hff; 8'h7e: r=8'hf3; 8'h7f: r=8'hd2;
      8'h80: r=8'hcd; 8'h81: r=8'h0c; 8'h82: r=8'h13; 8'h83: r=8'hec;
      8'h84: r=8'h5f; 8'h85: r=8'h97; 8'h86: r=8'h44; 8'h87: r=8'h17;
      8'h88: r=8'hc4; 8'h89: r=8'ha7; 8'h8a: r=8'h7e; 8'h8b: r=8'h3d;
      8'h8c: r=8'h64; 8'h8d: r=8'h5d; 8'h8e: r=8'h19; 8'h8f: r=8'h73;
      8'h90: r=8'h60; 8'h91: r=8'h81; 8'h92: r=8'h4f; 8'h93: r=8'hdc;
      8'h94: r=8'h22; 8'h95: r=8'h2a; 8'h96: r=8'h90; 8'h97: r=8'h88;
      8'h98: r=8'h46; 8'h99: r=8'hee; 8'h9a: r=8'hb8; 8'h9b: r=8'h14;
      8'h9c: r=8'hde; 8'h9d: r=8'h5e; 8'h9e: r=8'h0b; 8'h9f: r=8'hdb;
      8'ha0: r=8'he0; 8'ha1: r=8'h32; 8'ha2: r=8'h3a; 8'ha3: r=8'h0a;
      8'ha4: r=8'h49; 8'ha5: r=8'h06; 8'ha6: r=8'h24; 8'ha7: r=8'h5c;
      8'ha8: r=8'hc2; 8'ha9: r=8'hd3; 8'haa: r=8'hac; 8'hab: r=8'h62;
      8'hac: r=8'h91; 8'had: r=8'h95; 8'hae: r=8'he4; 8'haf: r=8'h79;
      8'hb0: r=8'he7; 8'hb1: r=8'hc8; 8'hb2: r=8'h37; 8'hb3: r=8'h6d;
      8'hb4: r=8'h8d; 8'hb5: r=8'hd5; 8'hb6: r=8'h4e; 8'hb7: r=8'ha9;
      8'hb8: r=8'h6c; 8'hb9: r=8'h56; 8'hba: r=8'hf4; 8'hbb: r=8'hea;
      8'hbc: r=8'h65; 8'hbd: r=8'h7a; 8'hbe: r=8'hae; 8'hbf: r=8'h08;
      8'hc0: r=8'hba; 8'hc1: r=8'h78; 8'hc2: r=8'h25; 8'hc3: r=8'h2e;
      8'hc4: r=8'h1c; 8'hc5: r=8'ha6; 8'hc6: r=8'hb4; 8'hc7: r=8'hc6;
      8'hc8: r=8'he8; 8'hc9: r=8'hdd; 8'hca: r=8'h74; 8'hcb: r=8'h1f;
      8'hcc: r=8'h4b; 8'hcd: r=8'hbd; 8'hce: r=8'h8b; 8'hcf: r=8'h8a;
      8'hd0: r=8'h70; 8'hd1: r=8'h3e; 8'hd2: r=8'hb5; 8'hd3: r=8'h66;
      8'hd4: r=8'h48; 8'hd5: r=8'h03; 8'hd6: r=8'hf6; 8'hd7: r=8'h0e;
      8'hd8: r=8'h61; 8'hd9: r=8'h35; 8'hda: r=8'h57; 8'hdb: r=8'hb9;
      8'hdc: r=8'h86; 8'hdd: r=8'hc1; 8'hde: r=8'h1d; 8'hdf: r=8'h9e;
      8'he0: r=8'he1; 8'he1: r=8'hf8; 8'he2: r=8'h98; 8'he3: r=8'h11;
      8'he4: r=8'h69; 8'he5: r=8'hd9; 8'he6: r=8'h8e; 8'he7: r=8'h94;
      8'he8: r=8'h9b; 8'he9: r=8'h1e; 8'hea: r=8'h87; 8'heb: r=8'he9;
      8'hec: r=8'hce; 8'hed: r=8'h55; 8'hee: r=8'h28; 8'hef: r=8'hdf;
      8'hf0: r=8'h8c; 8'hf1: r=8'ha1; 8'hf2: r=8'h89; 8'hf3: r=8'h0d;
      8'hf4: r=8'hbf; 8'hf5: r=8'he6; 8'hf6: r=8'h42; 8'hf7: r=8'h68;
      8'hf8: r=8'h41; 8'hf9: r=8'h99; 8'hfa: r=8'h2d; 8'hfb: r=8'h0f;
      8'hfc: r=8'hb0; 8'hfd: r=8'h54; 8'hfe: r=8'hbb; 8'hff: r=8'h16;
      default: r = 8'h00;
    endcase
    return r;
  endfunction

  // Round constant; rounds outside 1..10 get zero (key passes through anyway).
  function automatic byte_t rcon(input logic [3:0] rnd);
    byte_t r;
    case (rnd)
      4'd1:  r = 8'h01;
      4'd2:  r = 8'h02;
      4'd3:  r = 8'h04;
      4'd4:  r = 8'h08;
      4'd5:  r = 8'h10;
      4'd6:  r = 8'h20;
      4'd7:  r = 8'h40;
      4'd8:  r = 8'h80;
      4'd9:  r = 8'h1b;
      4'd10: r = 8'h36;
      default: r = 8'h00;
    endcase
    return r;
  endfunction

  // Multiply by x in GF(2^8).
  function automatic byte_t xtime(input byte_t a);
    return {a[6:0], 1'b0} ^ (a[7] ? GF_POLY : 8'h00);
  endfunction

endpackage

### hw/rtl/aes128r_lane.sv
// One column lane: SubBytes on its shifted bytes, optional MixColumns.
// Depends on aes128r_pkg.
module aes128r_lane
  import aes128r_pkg::*;
(
  input  word_t    col_in,   // shifted-in column bytes, row 0 in [31:24]
  input  word_t    col_raw,  // unshifted column for pass-through rounds
  input  rnd_ctl_t ctl,
  output word_t    col_out
);

  byte_t s0, s1, s2, s3;
  word_t mixed;

  // S-box per byte
  assign s0 = sbox(col_in[31:24]);
  assign s1 = sbox(col_in[23:16]);
  assign s2 = sbox(col_in[15:8]);
  assign s3 = sbox(col_in[7:0]);

  // MixColumns
  always_comb begin
    mixed[31:24] = xtime(s0) ^ xtime(s1) ^ s1 ^ s2 ^ s3;
    mixed[23:16] = s0 ^ xtime(s1) ^ xtime(s2) ^ s2 ^ s3;
    mixed[15:8]  = s0 ^ s1 ^ xtime(s2) ^ xtime(s3) ^ s3;
    mixed[7:0]   = xtime(s0) ^ s0 ^ s1 ^ s2 ^ xtime(s3);
  end

  assign col_out = !ctl.full ? col_raw : (ctl.mix ? mixed : {s0, s1, s2, s3});

endmodule

### hw/rtl/aes128r_ksched.sv
// Key expansion step: RotWord, SubWord, Rcon and the word chain.
// Depends on aes128r_pkg.
module aes128r_ksched
  import aes128r_pkg::*;
(
  input  logic [127:0] key_in,
  input  rnd_ctl_t     ctl,
  output logic [127:0] key_out
);

  word_t w0, w1, w2, w3, t, n0, n1, n2, n3;

  assign {w0, w1, w2, w3} = key_in;
  assign t  = {sbox(w3[23:16]) ^ ctl.rcon, sbox(w3[15:8]), sbox(w3[7:0]), sbox(w3[31:24])};
  assign n0 = w0 ^ t;
  assign n1 = w1 ^ n0;
  assign n2 = w2 ^ n1;
  assign n3 = w3 ^ n2;

  assign key_out = ctl.full ? {n0, n1, n2, n3} : key_in;

endmodule

### hw/rtl/aes128_round_with_key_schedule_top.sv
// Top level of the AES-128 round block: ShiftRows routing, four column lanes,
// key expansion, AddRoundKey merge and a skid-buffered output. Uses aes128r_pkg.
//
// One AES-128 round per beat: state and previous round key in, new state and
// the round key used out. Round 0 and codes 11..15 only XOR the key in; 1..9
// are full rounds; 10 skips MixColumns. Throughput is one beat per clock while
// out_stall is low; four column lanes plus the key step form the single
// combinational stage ahead of the output register, and a skid register keeps
// in_stall off the out_stall path.
module aes128_round_with_key_schedule_top
  import aes128r_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [63:0] in_state_high,
  input  logic [63:0] in_state_low,
  input  logic [63:0] in_key_high,
  input  logic [63:0] in_key_low,
  input  logic [3:0]  in_round_index,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [63:0] out_state_high,
  output logic [63:0] out_state_low,
  output logic [63:0] out_key_high,
  output logic [63:0] out_key_low
);

  rnd_ctl_t     ctl;
  logic [127:0] st, rk;
  logic [127:0] col_sh, res_st;
  word_t        lane_out [NUM_COLS];

  assign st = {in_state_high, in_state_low};
  assign ctl.full = (in_round_index >= ROUND_FIRST) && (in_round_index <= ROUND_LAST);
  assign ctl.mix  = ctl.full && (in_round_index != ROUND_LAST);
  assign ctl.rcon = rcon(in_round_index);

  // ShiftRows: output column c row r takes input column (c+r)%4 row r
  always_comb begin
    for (int c = 0; c < NUM_COLS; c++) begin
      for (int r = 0; r < 4; r++) begin
        col_sh[127 - 32*c - 8*r -: 8] = st[127 - 32*((c + r) % 4) - 8*r -: 8];
      end
    end
  end

  aes128r_ksched u_ks (
    .key_in  ({in_key_high, in_key_low}),
    .ctl     (ctl),
    .key_out (rk)
  );

  // Column lanes
  for (genvar g = 0; g < NUM_COLS; g++) begin : g_lane
    aes128r_lane u_lane (
      .col_in  (col_sh[127 - 32*g -: 32]),
      .col_raw (st[127 - 32*g -: 32]),
      .ctl     (ctl),
      .col_out (lane_out[g])
    );
  end

  // Merge lanes and AddRoundKey
  assign res_st = {lane_out[0], lane_out[1], lane_out[2], lane_out[3]} ^ rk;

  // Output register plus skid register
  logic         out_valid_r, skid_valid_r;
  logic [255:0] out_data_r, skid_data_r;
  logic         in_acc, out_acc;

  assign in_stall = skid_valid_r;
  assign in_acc   = in_valid && !skid_valid_r;
  assign out_acc  = out_valid_r && !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      if (!out_valid_r || out_acc) begin
        out_valid_r <= skid_valid_r || in_acc;
        skid_valid_r <= 1'b0;
      end else if (in_acc) begin
        skid_valid_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid_r || out_acc) begin
      out_data_r <= skid_valid_r ? skid_data_r : {res_st, rk};
    end
    if (in_acc && out_valid_r && !out_acc) begin
      skid_data_r <= {res_st, rk};
    end
  end

  assign out_valid = out_valid_r;
  assign {out_state_high, out_state_low, out_key_high, out_key_low} = out_data_r;

  // Skid only fills while the output register is held
  a_skid_needs_full: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r) else $error("skid holds data with empty output");
  // A stalled result holds until taken
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_stall |=> out_valid_r && $stable(out_data_r))
    else $error("stalled result changed");
  // After an accepted beat, out_valid is always high in the next cycle
  a_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> out_valid_r) else $error("accepted beat lost");

endmodule
